// ===== src/assert_macros.svh =====
// Assertion helpers shared by the block's modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside of reset
`define HBRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included
`define HBRS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/hbrs_pkg.sv =====
package hbrs_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_RECORDS_DEF = 16;
  localparam int KEY_BITS_DEF    = 32;

  // Bucket accounting
  localparam logic [15:0] HEADER_BYTES       = 16'd12;
  localparam logic [15:0] PER_RECORD_BYTES   = 16'd4;
  localparam logic [15:0] BUCKET_BYTES_RESET = 16'd512;

  typedef enum logic [1:0] {
    REQ_LOOKUP  = 2'd0,
    REQ_INSERT  = 2'd1,
    REQ_DELETE  = 2'd2,
    REQ_REPLACE = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [31:0] key;
    logic [15:0] rec_size;
    logic [31:0] rec_value;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] hit_value;
    logic [15:0] hit_size;
    logic [15:0] free_bytes;
    logic [4:0]  record_count;
  } rsp_t;

  // One record payload as held in the slot RAM
  typedef struct packed {
    logic [31:0] value;
    logic [15:0] size;
  } slot_data_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;   // capture the accepted request
    logic capture;    // register key search results
    logic exec;       // apply the update and load the result register
    logic cfg_write;  // new bucket size: empty the bucket
  } dp_cmd_t;

endpackage

// ===== src/hbrs_ram.sv =====
module hbrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/hbrs_ctrl.sv =====
`include "assert_macros.svh"

module hbrs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  output hbrs_pkg::dp_cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_t;

  state_t state;
  logic   can_finish;
  logic   req_acc;

  // Result register is free or being emptied this cycle
  assign can_finish = !rsp_valid || !rsp_stall;
  assign req_stall  = !((state == S_IDLE) || ((state == S_EXEC) && can_finish));
  assign req_acc    = req_valid && !req_stall;
  assign cfg_ready  = (state == S_IDLE);

  // Datapath commands
  always_comb begin
    cmd           = '0;
    cmd.load_req  = req_acc;
    cmd.capture   = (state == S_CMP);
    cmd.exec      = (state == S_EXEC) && can_finish;
    cmd.cfg_write = cfg_valid && cfg_ready;
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // A new result replaces the one leaving this cycle
      if (cmd.exec) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (can_finish) begin
            state <= req_acc ? S_CMP : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `HBRS_ASSERT(a_acc_to_cmp, req_acc |=> (state == S_CMP), "accepted request did not enter compare")
  `HBRS_ASSERT(a_cmp_to_exec, (state == S_CMP) |=> (state == S_EXEC), "compare not followed by execute")
  `HBRS_ASSERT(a_exec_sets_valid, cmd.exec |=> rsp_valid, "executed request left no result")

endmodule

// ===== src/hbrs_dp.sv =====
`include "assert_macros.svh"

module hbrs_dp #(
  parameter int MAX_RECORDS = hbrs_pkg::MAX_RECORDS_DEF,
  parameter int KEY_BITS    = hbrs_pkg::KEY_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  hbrs_pkg::dp_cmd_t cmd,
  input  hbrs_pkg::req_t    req_data,
  input  logic [15:0]       cfg_data,
  output hbrs_pkg::rsp_t    rsp_data
);

  localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int SLOT_W = $bits(hbrs_pkg::slot_data_t);

  hbrs_pkg::req_t     req_q;
  logic [MAX_RECORDS-1:0] valid_q;
  logic [KEY_BITS-1:0]    keys_q [MAX_RECORDS];
  logic [15:0]            budget;
  logic [CNT_W-1:0]       count;

  // Search results
  logic [KEY_BITS-1:0]    key_m;
  logic [MAX_RECORDS-1:0] match;
  logic                   hit_any, free_any;
  logic [IDX_W-1:0]       hit_idx, free_idx;
  logic                   hit_q, free_any_q;
  logic [IDX_W-1:0]       hit_idx_q, free_idx_q;

  // Execute stage
  hbrs_pkg::slot_data_t   rd_slot;
  logic [SLOT_W-1:0]      rd_raw;
  hbrs_pkg::slot_data_t   wr_slot;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [16:0]            ins_cost, rep_avail, rep_left;
  logic [17:0]            del_sum;
  logic                   ok;
  logic [15:0]            budget_next;
  logic [CNT_W-1:0]       count_next;
  logic                   set_valid, clr_valid;

  assign key_m = KEY_BITS'(req_q.key);

  // Parallel key compare and lowest free slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = MAX_RECORDS - 1; i >= 0; i--) begin
      match[i] = valid_q[i] && (keys_q[i] == key_m);
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    hit_any  = |match;
    free_any = !(&valid_q);
  end

  // Request and search registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req_data;
    end
    if (cmd.capture) begin
      hit_q      <= hit_any;
      hit_idx_q  <= hit_idx;
      free_any_q <= free_any;
      free_idx_q <= free_idx;
    end
  end

  // Record value and size, read at the hit slot during compare
  hbrs_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_RECORDS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_slot),
    .rd_addr (hit_idx),
    .rd_data (rd_raw)
  );

  assign rd_slot = rd_raw;

  // Budget arithmetic
  assign ins_cost  = {1'b0, req_q.rec_size} + 17'(hbrs_pkg::PER_RECORD_BYTES);
  assign del_sum   = {2'b00, budget} + {2'b00, rd_slot.size}
                   + 18'(hbrs_pkg::PER_RECORD_BYTES);
  assign rep_avail = {1'b0, budget} + {1'b0, rd_slot.size};
  assign rep_left  = rep_avail - {1'b0, req_q.rec_size};

  // Request decode and update
  always_comb begin
    ok          = 1'b0;
    budget_next = budget;
    count_next  = count;
    wr_en       = 1'b0;
    wr_addr     = hit_idx_q;
    wr_slot     = '{value: req_q.rec_value, size: req_q.rec_size};
    set_valid   = 1'b0;
    clr_valid   = 1'b0;
    unique case (req_q.req_type)
      hbrs_pkg::REQ_LOOKUP: begin
        ok = hit_q;
      end
      hbrs_pkg::REQ_INSERT: begin
        if (!hit_q && free_any_q && (ins_cost <= {1'b0, budget})) begin
          ok          = 1'b1;
          budget_next = budget - ins_cost[15:0];
          count_next  = count + CNT_W'(1);
          wr_addr     = free_idx_q;
          set_valid   = 1'b1;
        end
      end
      hbrs_pkg::REQ_DELETE: begin
        if (hit_q) begin
          ok          = 1'b1;
          budget_next = (del_sum[17:16] != 2'b00) ? 16'hFFFF : del_sum[15:0];
          count_next  = count - CNT_W'(1);
          clr_valid   = 1'b1;
        end
      end
      hbrs_pkg::REQ_REPLACE: begin
        if (hit_q && (rep_avail >= {1'b0, req_q.rec_size})) begin
          ok          = 1'b1;
          budget_next = rep_left[16] ? 16'hFFFF : rep_left[15:0];
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    wr_en = cmd.exec && ok
         && ((req_q.req_type == hbrs_pkg::REQ_INSERT)
          || (req_q.req_type == hbrs_pkg::REQ_REPLACE));
  end

  // Bucket state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
      count   <= '0;
      budget  <= hbrs_pkg::BUCKET_BYTES_RESET - hbrs_pkg::HEADER_BYTES;
    end else if (cmd.cfg_write) begin
      valid_q <= '0;
      count   <= '0;
      budget  <= (cfg_data >= hbrs_pkg::HEADER_BYTES) ?
                 cfg_data - hbrs_pkg::HEADER_BYTES : 16'd0;
    end else if (cmd.exec) begin
      budget <= budget_next;
      count  <= count_next;
      if (set_valid) begin
        valid_q[free_idx_q] <= 1'b1;
      end
      if (clr_valid) begin
        valid_q[hit_idx_q] <= 1'b0;
      end
    end
  end

  // Key store
  always_ff @(posedge clk) begin
    if (cmd.exec && set_valid) begin
      keys_q[free_idx_q] <= key_m;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp_data.ok           <= ok;
      rsp_data.hit_value    <= (req_q.req_type == hbrs_pkg::REQ_LOOKUP && hit_q) ?
                               rd_slot.value : 32'd0;
      rsp_data.hit_size     <= (req_q.req_type == hbrs_pkg::REQ_LOOKUP && hit_q) ?
                               rd_slot.size : 16'd0;
      rsp_data.free_bytes   <= budget_next;
      rsp_data.record_count <= 5'(count_next);
    end
  end

  `HBRS_ASSERT_ALWAYS(a_count_matches, (rst || (int'(count) == $countones(valid_q))), "record count disagrees with valid slots")
  `HBRS_ASSERT(a_count_bound, (int'(count) <= MAX_RECORDS), "record count above slot count")
  `HBRS_ASSERT(a_insert_has_slot, (cmd.exec && set_valid) |-> !valid_q[free_idx_q], "insert into an occupied slot")

endmodule

// ===== src/hash_bucket_record_store_core.sv =====
// Hash bucket record store: holds up to MAX_RECORDS records with unique keys and
// answers lookup, insert, delete and replace requests with one response each.
// A request passes a compare state, then an execute state, to its response
// register: compare checks the key against all slots in parallel and addresses
// the slot RAM at the hit slot; execute takes the RAM read data, updates the
// budget and writes the record. With the response taken promptly, a new request
// is accepted in the execute state of the one before; a stalled response holds
// off the next request only once that one has finished its compare. Writing
// bucket_bytes empties the bucket and reloads the free budget in the same cycle;
// there is no clearing pass after reset. Keys compare on their low KEY_BITS bits.
module hash_bucket_record_store_core #(
  parameter int MAX_RECORDS = hbrs_pkg::MAX_RECORDS_DEF,
  parameter int KEY_BITS    = hbrs_pkg::KEY_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  hbrs_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output hbrs_pkg::rsp_t rsp_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [15:0]    cfg_data
);

  hbrs_pkg::dp_cmd_t cmd;

  hbrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  hbrs_dp #(
    .MAX_RECORDS (MAX_RECORDS),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req_data (req_data),
    .cfg_data (cfg_data),
    .rsp_data (rsp_data)
  );

endmodule
